// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the timing core checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

// File: hw/rtl/lcdsmt_pkg.sv
// ----------------------------------------------------------------------------
// lcdsmt_pkg
// Types, codes and timing constants of the LCD scanline mode timer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lcdsmt_pkg;

	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	localparam logic [1:0] MODE_HBLANK = 2'd0;
	localparam logic [1:0] MODE_VBLANK = 2'd1;
	localparam logic [1:0] MODE_OAM    = 2'd2;
	localparam logic [1:0] MODE_DRAW   = 2'd3;

	localparam logic [7:0] ADDR_CTRL = 8'h40;
	localparam logic [7:0] ADDR_STAT = 8'h41;
	localparam logic [7:0] ADDR_LY   = 8'h44;
	localparam logic [7:0] ADDR_LYC  = 8'h45;
	localparam logic [7:0] ADDR_WY   = 8'h4A;
	localparam logic [7:0] ADDR_WX   = 8'h4B;

	localparam logic [8:0] OAM_DOTS    = 9'd80;
	localparam logic [8:0] DRAW_DOTS   = 9'd172;
	localparam logic [8:0] HBLANK_DOTS = 9'd204;
	localparam logic [8:0] LINE_DOTS   = 9'd456;
	localparam logic [7:0] LAST_VISIBLE = 8'd143;
	localparam logic [7:0] LAST_LINE    = 8'd153;
	localparam logic [7:0] WX_LIMIT     = 8'd167;
	localparam logic [7:0] WY_LIMIT     = 8'd144;
	localparam logic [7:0] CTRL_RESET   = 8'h91;
	localparam logic [7:0] STAT_RESET   = 8'h84;

	typedef struct packed {
		logic [1:0] mode;
		logic [8:0] dot;
		logic [7:0] line;
		logic [7:0] win;
		logic [7:0] ctrl;
		logic [7:0] stat;
		logic [7:0] lyc;
		logic [7:0] wy;
		logic [7:0] wx;
	} state_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [1:0] lcd_mode;
		logic [7:0] line;
		logic [7:0] window_line;
		logic       vblank_irq;
		logic       stat_irq;
		logic       start_oam_scan;
		logic       render_line;
	} result_t;

	localparam state_t STATE_RESET = '{
		mode: MODE_OAM,
		dot:  9'd0,
		line: 8'd0,
		win:  8'd0,
		ctrl: CTRL_RESET,
		stat: STAT_RESET,
		lyc:  8'd0,
		wy:   8'd0,
		wx:   8'd0
	};

endpackage

// File: hw/rtl/lcdsmt_step.sv
// ----------------------------------------------------------------------------
// lcdsmt_step
// Next-state and result logic for one tick, register write or register read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcdsmt_step (
	input  lcdsmt_pkg::state_t  st,
	input  logic [1:0]          kind,
	input  logic [7:0]          reg_addr,
	input  logic [7:0]          write_data,
	output lcdsmt_pkg::state_t  nx,
	output lcdsmt_pkg::result_t res
);
	import lcdsmt_pkg::*;

	// {irq, status} after the line-compare rule
	function automatic logic [8:0] cmp_fn(input logic [7:0] lyc, input logic [7:0] ly,
			input logic [7:0] stat, input logic en);
		logic [7:0] s;
		logic       irq;
		s   = stat;
		irq = 1'b0;
		if (lyc == ly) begin
			s   = stat | 8'h04;
			irq = s[6];
		end else if (en) begin
			s = stat & 8'hFB;
		end
		return {irq, s};
	endfunction

	// {irq, status} after the mode-change rule
	function automatic logic [8:0] mode_fn(input logic [7:0] stat, input logic [1:0] m);
		logic [7:0] s;
		s = {stat[7:2], m};
		return {s[3'(m) + 3'd3], s};
	endfunction

	logic [8:0] dot_inc;
	logic [8:0] chk_a;
	logic [8:0] chk_b;
	logic [7:0] val;
	logic [7:0] rd;
	logic       irq_v;
	logic       irq_s;
	logic       scan;
	logic       render;

	always_comb begin
		nx      = st;
		rd      = 8'd0;
		irq_v   = 1'b0;
		irq_s   = 1'b0;
		scan    = 1'b0;
		render  = 1'b0;
		chk_a   = 9'd0;
		chk_b   = 9'd0;
		val     = write_data;
		dot_inc = st.dot + 9'd1;
		case (kind)
			KIND_TICK: begin
				if (st.ctrl[7]) begin
					nx.dot = dot_inc;
					case (st.mode)
						MODE_OAM: begin
							if (dot_inc == OAM_DOTS) begin
								nx.mode = MODE_DRAW;
								nx.dot  = 9'd0;
								nx.stat = {st.stat[7:2], MODE_DRAW};
								scan    = 1'b1;
							end
						end
						MODE_DRAW: begin
							if (dot_inc == DRAW_DOTS) begin
								nx.mode = MODE_HBLANK;
								nx.dot  = 9'd0;
								render  = 1'b1;
								chk_a   = mode_fn(st.stat, MODE_HBLANK);
								nx.stat = chk_a[7:0];
								irq_s   = chk_a[8];
							end
						end
						MODE_HBLANK: begin
							if (dot_inc == HBLANK_DOTS) begin
								nx.dot = 9'd0;
								if (st.wx < WX_LIMIT && st.wy < WY_LIMIT)
									nx.win = st.win + 8'd1;
								if (st.line == LAST_VISIBLE) begin
									nx.mode = MODE_VBLANK;
									nx.win  = 8'd0;
									irq_v   = 1'b1;
								end else begin
									nx.mode = MODE_OAM;
								end
								chk_a   = mode_fn(st.stat, nx.mode);
								nx.line = st.line + 8'd1;
								chk_b   = cmp_fn(st.lyc, nx.line, chk_a[7:0], st.ctrl[7]);
								nx.stat = chk_b[7:0];
								irq_s   = chk_a[8] | chk_b[8];
							end
						end
						default: begin
							if (dot_inc == LINE_DOTS) begin
								nx.dot = 9'd0;
								if (st.line == LAST_LINE) begin
									nx.line = 8'd0;
									nx.mode = MODE_OAM;
									chk_a   = cmp_fn(st.lyc, 8'd0, st.stat, st.ctrl[7]);
									chk_b   = mode_fn(chk_a[7:0], MODE_OAM);
									nx.stat = chk_b[7:0];
									irq_s   = chk_a[8] | chk_b[8];
								end else begin
									nx.line = st.line + 8'd1;
									chk_a   = cmp_fn(st.lyc, nx.line, st.stat, st.ctrl[7]);
									nx.stat = chk_a[7:0];
									irq_s   = chk_a[8];
								end
							end
						end
					endcase
				end
			end
			KIND_WRITE: begin
				case (reg_addr)
					ADDR_CTRL: begin
						if (!val[0])
							val[5] = 1'b0;
						if (!val[7]) begin
							nx.line = 8'd0;
							nx.dot  = 9'd0;
							nx.mode = MODE_HBLANK;
							nx.stat = {st.stat[7:2], MODE_HBLANK};
						end
						if (val[7] && !st.ctrl[7]) begin
							nx.mode = MODE_OAM;
							chk_a   = cmp_fn(st.lyc, st.line, st.stat, st.ctrl[7]);
							chk_b   = mode_fn(chk_a[7:0], MODE_OAM);
							nx.stat = chk_b[7:0];
							irq_s   = chk_a[8] | chk_b[8];
						end
						nx.ctrl = val;
					end
					ADDR_STAT: nx.stat = write_data;
					ADDR_LYC: begin
						nx.lyc  = write_data;
						chk_a   = cmp_fn(write_data, st.line, st.stat, st.ctrl[7]);
						nx.stat = chk_a[7:0];
						irq_s   = chk_a[8];
					end
					ADDR_WY: nx.wy = write_data;
					ADDR_WX: nx.wx = write_data;
					default: ;
				endcase
			end
			KIND_READ: begin
				case (reg_addr)
					ADDR_CTRL: rd = st.ctrl;
					ADDR_STAT: rd = st.stat;
					ADDR_LY:   rd = st.line;
					ADDR_LYC:  rd = st.lyc;
					ADDR_WY:   rd = st.wy;
					ADDR_WX:   rd = st.wx;
					default:   rd = 8'hFF;
				endcase
			end
			default: ;
		endcase
	end

	assign res = '{
		read_data:      rd,
		lcd_mode:       nx.mode,
		line:           nx.line,
		window_line:    nx.win,
		vblank_irq:     irq_v,
		stat_irq:       irq_s,
		start_oam_scan: scan,
		render_line:    render
	};

endmodule

// File: hw/rtl/lcd_scanline_mode_timer_core.sv
// ----------------------------------------------------------------------------
// lcd_scanline_mode_timer_core
// Dot-clock scanline and mode timer of a handheld LCD controller.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one transfer per step: a dot tick,
// a register write or a register read (kind, reg_addr, write_data).
// Output channel (out_valid/out_ready): one transfer per input step with the
// read data, mode, line and window line after the step, and the vblank,
// status, sprite-scan and render pulses raised by it.
// Path: an accepted step is held in the input register, then the result
// register is loaded together with the timing state and out_valid rises.
// Throughput: one step per cycle while out_ready is high; the state update is a single
// combinational pass from the input register into the state registers.
// Stall: when a result waits with out_ready low, the result register holds, the input register
// fills, and in_ready drops until the result is taken.
// Reset: arst_n clears both valid flags and loads the timing state to
// OAM scan, line 0, dot 0, control 0x91, status 0x84, other registers 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcd_scanline_mode_timer_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] kind,
	input  logic [7:0] reg_addr,
	input  logic [7:0] write_data,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data,
	output logic [1:0] lcd_mode,
	output logic [7:0] line,
	output logic [7:0] window_line,
	output logic       vblank_irq,
	output logic       stat_irq,
	output logic       start_oam_scan,
	output logic       render_line
);
	import lcdsmt_pkg::*;

	logic       valid_s1;
	logic [1:0] kind_s1;
	logic [7:0] addr_s1;
	logic [7:0] data_s1;
	logic       out_valid_q;
	logic       advance;
	state_t     state_q;
	state_t     state_nx;
	result_t    res_nx;
	result_t    res_q;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	lcdsmt_step u_step (
		.st         (state_q),
		.kind       (kind_s1),
		.reg_addr   (addr_s1),
		.write_data (data_s1),
		.nx         (state_nx),
		.res        (res_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= STATE_RESET;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance) begin
				state_q     <= state_nx;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1 <= kind;
			addr_s1 <= reg_addr;
			data_s1 <= write_data;
		end
		if (advance)
			res_q <= res_nx;
	end

	assign out_valid      = out_valid_q;
	assign read_data      = res_q.read_data;
	assign lcd_mode       = res_q.lcd_mode;
	assign line           = res_q.line;
	assign window_line    = res_q.window_line;
	assign vblank_irq     = res_q.vblank_irq;
	assign stat_irq       = res_q.stat_irq;
	assign start_oam_scan = res_q.start_oam_scan;
	assign render_line    = res_q.render_line;

endmodule

// File: hw/rtl/lcdsmt_checker.sv
// ----------------------------------------------------------------------------
// lcdsmt_checker
// Port-level assertions for the scanline mode timer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lcdsmt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] kind,
	input logic [7:0] reg_addr,
	input logic [7:0] write_data,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] read_data,
	input logic [1:0] lcd_mode,
	input logic [7:0] line,
	input logic [7:0] window_line,
	input logic       vblank_irq,
	input logic       stat_irq,
	input logic       start_oam_scan,
	input logic       render_line
);
	import lcdsmt_pkg::*;

	logic stalled;
	logic vblank_ok;
	logic scan_ok;

	assign stalled   = out_valid && !out_ready;
	assign vblank_ok = lcd_mode == MODE_VBLANK && line == WY_LIMIT && window_line == 8'd0;
	assign scan_ok   = lcd_mode == MODE_DRAW && !render_line && !vblank_irq;

	// stalled result transfer holds its payload
	`ASSERT_NEXT(a_out_hold, clk, arst_n, stalled, out_valid && $stable(read_data) && $stable(line) && $stable(lcd_mode))
	// vblank request only on entry to the first vblank line
	`ASSERT_IMPL(a_vblank_entry, clk, arst_n, out_valid && vblank_irq, vblank_ok)
	// sprite scan trigger only on entering drawing
	`ASSERT_IMPL(a_scan_mode, clk, arst_n, out_valid && start_oam_scan, scan_ok)
	// render trigger only on entering hblank
	`ASSERT_IMPL(a_render_mode, clk, arst_n, out_valid && render_line, lcd_mode == MODE_HBLANK)

endmodule

bind lcd_scanline_mode_timer_core lcdsmt_checker u_lcdsmt_checker (.*);

// File: tb/tb_lcd_scanline_mode_timer_core.sv
// ----------------------------------------------------------------------------
// tb_lcd_scanline_mode_timer_core
// Self-checking bench for the LCD scanline mode timer. A queue of steps
// (dot ticks, register writes and reads) feeds a valid/ready driver. Each
// accepted transfer runs through a cycle-exact timing model kept in the
// bench, and every result transfer is compared field by field against the
// oldest predicted result. Directed register checks come first, then random
// traffic with short tick bursts and a tick run across a full line.
// Both sides idle at random, with two long output hold-offs and two drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lcd_scanline_mode_timer_core;

	import lcdsmt_pkg::*;

	localparam logic [1:0] KIND_NONE = 2'd3;

	typedef struct {
		logic [1:0]  kind;
		logic [7:0]  addr;
		logic [7:0]  data;
		int unsigned gap;
		bit          quiet;
		bit          drain;
		bit          choke;
	} lcd_step_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] kind = KIND_TICK;
	logic [7:0] reg_addr = 8'h00;
	logic [7:0] write_data = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] read_data;
	logic [1:0] lcd_mode;
	logic [7:0] line;
	logic [7:0] window_line;
	logic       vblank_irq;
	logic       stat_irq;
	logic       start_oam_scan;
	logic       render_line;

	lcd_step_t   steps_to_send[$];
	result_t     predicted_results[$];
	state_t      timing;
	logic        stat_raised;
	lcd_step_t   cur;
	bit          loaded = 1'b0;
	int unsigned gap_left = 0;
	bit          took_in = 1'b0;
	bit          took_out = 1'b0;
	bit          quiet_phase = 1'b0;
	int          choke_cnt = 0;
	int          choke_seen = 0;
	int          hold_left = 0;
	int          stall_left = 0;
	int          mismatch_cnt = 0;
	int          cycle_cnt = 0;
	int          cycle_limit = 0;

	lcd_scanline_mode_timer_core dut (.*);

	always #6 clk = ~clk;

	// line-compare rule
	function automatic void match_line();
		if (timing.lyc == timing.line) begin
			timing.stat[2] = 1'b1;
			if (timing.stat[6])
				stat_raised = 1'b1;
		end else if (timing.ctrl[7]) begin
			timing.stat[2] = 1'b0;
		end
	endfunction

	// mode bits update plus mode interrupt enable check
	function automatic void post_mode();
		timing.stat[1:0] = timing.mode;
		if (timing.stat[3 + timing.mode])
			stat_raised = 1'b1;
	endfunction

	function automatic result_t step_timing(logic [1:0] k, logic [7:0] a, logic [7:0] d);
		result_t    r;
		logic [7:0] v;
		r = '0;
		v = d;
		stat_raised = 1'b0;
		case (k)
		KIND_TICK: if (timing.ctrl[7]) begin
			timing.dot = timing.dot + 9'd1;
			case (timing.mode)
			MODE_OAM: if (timing.dot == OAM_DOTS) begin
				timing.mode = MODE_DRAW;
				timing.dot = '0;
				timing.stat[1:0] = MODE_DRAW;
				r.start_oam_scan = 1'b1;
			end
			MODE_DRAW: if (timing.dot == DRAW_DOTS) begin
				timing.mode = MODE_HBLANK;
				timing.dot = '0;
				r.render_line = 1'b1;
				post_mode();
			end
			MODE_HBLANK: if (timing.dot == HBLANK_DOTS) begin
				if (timing.wx < WX_LIMIT && timing.wy < WY_LIMIT)
					timing.win = timing.win + 8'd1;
				timing.dot = '0;
				if (timing.line == LAST_VISIBLE) begin
					timing.mode = MODE_VBLANK;
					timing.win = '0;
					r.vblank_irq = 1'b1;
				end else begin
					timing.mode = MODE_OAM;
				end
				post_mode();
				timing.line = timing.line + 8'd1;
				match_line();
			end
			MODE_VBLANK: if (timing.dot == LINE_DOTS) begin
				timing.dot = '0;
				if (timing.line == LAST_LINE) begin
					timing.line = '0;
					timing.mode = MODE_OAM;
					match_line();
					post_mode();
				end else begin
					timing.line = timing.line + 8'd1;
					match_line();
				end
			end
			default: ;
			endcase
		end
		KIND_WRITE: case (a)
			ADDR_CTRL: begin
				if (!v[0])
					v[5] = 1'b0;
				if (!v[7]) begin
					timing.line = '0;
					timing.dot = '0;
					timing.mode = MODE_HBLANK;
					timing.stat[1:0] = MODE_HBLANK;
				end
				// turn-on compares against the old control value
				if (v[7] && !timing.ctrl[7]) begin
					timing.mode = MODE_OAM;
					match_line();
					post_mode();
				end
				timing.ctrl = v;
			end
			ADDR_STAT: timing.stat = v;
			ADDR_LYC: begin
				timing.lyc = v;
				match_line();
			end
			ADDR_WY: timing.wy = v;
			ADDR_WX: timing.wx = v;
			default: ;
		endcase
		KIND_READ: case (a)
			ADDR_CTRL: r.read_data = timing.ctrl;
			ADDR_STAT: r.read_data = timing.stat;
			ADDR_LY:   r.read_data = timing.line;
			ADDR_LYC:  r.read_data = timing.lyc;
			ADDR_WY:   r.read_data = timing.wy;
			ADDR_WX:   r.read_data = timing.wx;
			default:   r.read_data = 8'hFF;
		endcase
		default: ;
		endcase
		r.lcd_mode = timing.mode;
		r.line = timing.line;
		r.window_line = timing.win;
		r.stat_irq = stat_raised;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
		if (mismatch_cnt < 100)
			$display("%0t: %s got %h want %h", $time, what, got, want);
		mismatch_cnt++;
	endtask

	task automatic push_step(logic [1:0] k, logic [7:0] a, logic [7:0] d,
			bit quiet = 1'b0, bit drain = 1'b0, bit choke = 1'b0);
		lcd_step_t s;
		s.kind = k;
		s.addr = a;
		s.data = d;
		s.gap = quiet ? 0 : $urandom_range(0, 9);
		s.quiet = quiet;
		s.drain = drain;
		s.choke = choke;
		steps_to_send.insert(steps_to_send.size(), s);
	endtask

	task automatic push_ticks(int n, bit quiet);
		repeat (n)
			push_step(KIND_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				quiet);
	endtask

	task automatic push_reg_op(bit allow_off);
		logic [1:0] k;
		logic [7:0] a;
		logic [7:0] d;
		case ($urandom_range(0, 7))
		0: a = ADDR_CTRL;
		1: a = ADDR_STAT;
		2: a = ADDR_LY;
		3: a = ADDR_LYC;
		4: a = ADDR_WY;
		5: a = ADDR_WX;
		default: a = 8'($urandom_range(0, 255));
		endcase
		k = $urandom_range(0, 1) ? KIND_WRITE : KIND_READ;
		if ($urandom_range(0, 99) == 0)
			k = KIND_NONE;
		d = 8'($urandom_range(0, 255));
		if (a == ADDR_CTRL && (!allow_off || $urandom_range(0, 9) != 0))
			d[7] = 1'b1;
		if (a == ADDR_LYC && $urandom_range(0, 3) != 0)
			d = 8'($urandom_range(0, LAST_LINE));
		if (a == ADDR_WX && $urandom_range(0, 1))
			d = 8'(WX_LIMIT - $urandom_range(0, 1));
		if (a == ADDR_WY && $urandom_range(0, 1))
			d = 8'(WY_LIMIT - $urandom_range(0, 1));
		push_step(k, a, d);
	endtask

	// driver
	always @(negedge clk) begin
		bit go;
		go = 1'b0;
		if (arst_n) begin
			if (in_valid && took_in)
				loaded = 1'b0;
			if (!loaded && steps_to_send.size() != 0) begin
				cur = steps_to_send.pop_front();
				loaded = 1'b1;
				gap_left = cur.gap;
				if (cur.choke)
					choke_cnt <= choke_cnt + 1;
			end
			if (loaded) begin
				if (in_valid && !took_in)
					go = 1'b1;
				else if (gap_left != 0)
					gap_left--;
				else if (!cur.drain || predicted_results.size() == 0)
					go = 1'b1;
			end
		end
		in_valid <= go;
		if (go) begin
			kind <= cur.kind;
			reg_addr <= cur.addr;
			write_data <= cur.data;
			quiet_phase <= cur.quiet;
		end
	end

	// result sink
	always @(negedge clk) begin
		if (arst_n) begin
			if (choke_seen != choke_cnt) begin
				choke_seen = choke_cnt;
				hold_left = 80;
			end
			if (took_out)
				stall_left = quiet_phase ? 0 : $urandom_range(0, 9);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			timing = STATE_RESET;
			took_in = 1'b0;
			took_out = 1'b0;
		end else begin
			took_in = in_valid && in_ready;
			took_out = out_valid && out_ready;
			if (took_in)
				predicted_results.insert(predicted_results.size(),
					step_timing(kind, reg_addr, write_data));
			if (took_out) begin
				if (predicted_results.size() == 0) begin
					report_mismatch("unexpected result, lcd_mode", lcd_mode, 8'h00);
				end else begin
					want = predicted_results.pop_front();
					got = {read_data, lcd_mode, line, window_line,
						vblank_irq, stat_irq, start_oam_scan, render_line};
					if (got.read_data !== want.read_data)
						report_mismatch("read_data", got.read_data, want.read_data);
					if (got.lcd_mode !== want.lcd_mode)
						report_mismatch("lcd_mode", got.lcd_mode, want.lcd_mode);
					if (got.line !== want.line)
						report_mismatch("line", got.line, want.line);
					if (got.window_line !== want.window_line)
						report_mismatch("window_line", got.window_line, want.window_line);
					if (got.vblank_irq !== want.vblank_irq)
						report_mismatch("vblank_irq", got.vblank_irq, want.vblank_irq);
					if (got.stat_irq !== want.stat_irq)
						report_mismatch("stat_irq", got.stat_irq, want.stat_irq);
					if (got.start_oam_scan !== want.start_oam_scan)
						report_mismatch("start_oam_scan", got.start_oam_scan,
							want.start_oam_scan);
					if (got.render_line !== want.render_line)
						report_mismatch("render_line", got.render_line, want.render_line);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > cycle_limit) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		int r;
		// register subset at reset values, unknown addresses, ignored writes, window and status writes
		push_step(KIND_READ, ADDR_CTRL, 8'h00);
		push_step(KIND_READ, ADDR_STAT, 8'h00);
		push_step(KIND_READ, ADDR_LY, 8'h00);
		push_step(KIND_READ, ADDR_LYC, 8'h00);
		push_step(KIND_READ, ADDR_WY, 8'h00);
		push_step(KIND_READ, ADDR_WX, 8'h00);
		push_step(KIND_READ, 8'h00, 8'h00);
		push_step(KIND_READ, 8'hFF, 8'hFF);
		push_step(KIND_WRITE, 8'hFF, 8'hFF);
		push_step(KIND_WRITE, 8'h00, 8'h00);
		push_step(KIND_WRITE, ADDR_LY, 8'hFF);
		push_step(KIND_WRITE, ADDR_WX, 8'hFF);
		push_step(KIND_WRITE, ADDR_WY, 8'hFF);
		push_step(KIND_WRITE, ADDR_STAT, 8'hFF);
		// compare miss, then hit with the match interrupt enabled
		push_step(KIND_WRITE, ADDR_LYC, 8'hFF);
		push_step(KIND_WRITE, ADDR_LYC, 8'h00);
		// display off with bit 0 clear, so bit 5 is dropped
		push_step(KIND_WRITE, ADDR_CTRL, 8'h20);
		push_step(KIND_TICK, 8'hFF, 8'hFF);
		push_step(KIND_NONE, 8'hFF, 8'hFF);
		push_step(KIND_READ, ADDR_CTRL, 8'h00);
		// turn-on: oam scan, compare and mode check
		push_step(KIND_WRITE, ADDR_CTRL, 8'hFF);
		push_step(KIND_WRITE, ADDR_CTRL, 8'hA1);
		push_step(KIND_WRITE, ADDR_WX, 8'h00);
		push_step(KIND_WRITE, ADDR_WY, 8'h00);
		push_step(KIND_WRITE, ADDR_STAT, 8'h78);

		for (int i = 0; i < 600; i++) begin
			if (i == 150 || i == 450) begin
				push_step(KIND_READ, ADDR_LY, 8'h00, 1'b1, 1'b0, 1'b1);
				push_ticks(12, 1'b1);
				push_step(KIND_READ, ADDR_STAT, 8'h00, 1'b0, 1'b1, 1'b0);
			end
			r = $urandom_range(0, 99);
			if (r < 4)
				push_ticks($urandom_range(1, 20), 1'b1);
			else if (r < 55)
				push_step(KIND_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			else
				push_reg_op(1'b1);
		end

		// display stays on for more than a full line
		push_step(KIND_WRITE, ADDR_CTRL, 8'h91);
		repeat (5) begin
			push_ticks(100, 1'b1);
			push_reg_op(1'b0);
		end

		cycle_limit = 30 * steps_to_send.size() + 50000;

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		while (steps_to_send.size() != 0 || loaded || in_valid)
			@(posedge clk);
		while (predicted_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: lcd_scanline_mode_timer_core.f
+incdir+hw/rtl
hw/rtl/lcdsmt_pkg.sv
hw/rtl/lcdsmt_step.sv
hw/rtl/lcd_scanline_mode_timer_core.sv
hw/rtl/lcdsmt_checker.sv
tb/tb_lcd_scanline_mode_timer_core.sv
